// ===== src/pvp_pkg.sv =====
// Package: constants, widths and shared types of the perspective vertex projector.
`timescale 1ns / 1ps
`default_nettype none
package pvp_pkg;
  localparam int HALF_WIDTH  = 960;
  localparam int HALF_HEIGHT = 540;
  localparam int FRAC_BITS   = 16;

  localparam int COORD_W = 32;
  localparam int DIFF_W  = COORD_W + 1;
  localparam int UREG_W  = 31;
  localparam int P_W     = DIFF_W + UREG_W;
  localparam int HALF_MAX = (HALF_WIDTH > HALF_HEIGHT) ? HALF_WIDTH : HALF_HEIGHT;
  localparam int HALF_W  = $clog2(HALF_MAX + 1);
  localparam int N_W     = P_W + HALF_W;
  localparam int DEN_W   = UREG_W + FRAC_BITS;
  // quotient bits; any quotient at or above 2^QW saturates the 16-bit result
  localparam int QW      = 16;
  localparam int T_W     = QW + 3;
  localparam int SCR_W   = 16;

  localparam logic [2:0] CFG_CAMERA_X   = 3'd0;
  localparam logic [2:0] CFG_CAMERA_Y   = 3'd1;
  localparam logic [2:0] CFG_CAMERA_Z   = 3'd2;
  localparam logic [2:0] CFG_NEAR_PLANE = 3'd3;
  localparam logic [2:0] CFG_FAR_PLANE  = 3'd4;
  localparam logic [2:0] CFG_PROJ_SCALE = 3'd5;

  typedef struct packed {
    logic [COORD_W-1:0] camera_x;
    logic [COORD_W-1:0] camera_y;
    logic [COORD_W-1:0] camera_z;
    logic [UREG_W-1:0]  near_plane;
    logic [UREG_W-1:0]  far_plane;
    logic [UREG_W-1:0]  proj_scale;
  } pvp_cfg_t;

  typedef struct packed {
    logic [DEN_W-1:0] rem;
    logic [QW-1:0]    num_lo;
    logic [QW-1:0]    quo;
    logic             ov;
    logic             neg;
  } pvp_lane_t;

  typedef struct packed {
    pvp_lane_t         lx;
    pvp_lane_t         ly;
    logic [DEN_W-1:0]  den;
    logic              vis;
    logic [UREG_W-1:0] depth;
  } pvp_cell_t;
endpackage
`default_nettype wire

// ===== src/pvp_if.sv =====
// Interfaces: vertex input channel and projection result channel.
`timescale 1ns / 1ps
`default_nettype none
interface pvp_vertex_if;
  logic                        valid;
  logic                        ready;
  logic [pvp_pkg::COORD_W-1:0] vertex_x;
  logic [pvp_pkg::COORD_W-1:0] vertex_y;
  logic [pvp_pkg::COORD_W-1:0] vertex_z;
  modport source (output valid, output vertex_x, output vertex_y, output vertex_z,
                  input ready);
  modport sink (input valid, input vertex_x, input vertex_y, input vertex_z,
                output ready);
endinterface

interface pvp_result_if;
  logic                        valid;
  logic                        ready;
  logic                        visible;
  logic [pvp_pkg::SCR_W-1:0]   scr_col;
  logic [pvp_pkg::SCR_W-1:0]   scr_row;
  logic [pvp_pkg::UREG_W-1:0]  depth;
  modport source (output valid, output visible, output scr_col, output scr_row,
                  output depth, input ready);
  modport sink (input valid, input visible, input scr_col, input scr_row,
                input depth, output ready);
endinterface
`default_nettype wire

// ===== src/pvp_front.sv =====
// Front end: camera offset, clip test, magnitude products and divider setup.
`timescale 1ns / 1ps
`default_nettype none
module pvp_front (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          en_i,
  input  wire logic                          vld_i,
  input  wire logic [pvp_pkg::COORD_W-1:0]   vx_i,
  input  wire logic [pvp_pkg::COORD_W-1:0]   vy_i,
  input  wire logic [pvp_pkg::COORD_W-1:0]   vz_i,
  input  wire pvp_pkg::pvp_cfg_t             cfg_i,
  output logic                               vld_o,
  output pvp_pkg::pvp_cell_t                 data_o
);
  logic [2:0] vld_q;
  logic       vld4_q;

  // stage 1
  logic signed [pvp_pkg::DIFF_W-1:0] dx, dy, dz;
  logic [pvp_pkg::DIFF_W-1:0] magx_q, magy_q;
  logic negx_q, negy_q, vis1_q;
  logic [pvp_pkg::UREG_W-1:0] dz1_q, scale1_q;
  // stage 2
  logic [pvp_pkg::P_W-1:0] px_q, py_q;
  logic negx2_q, negy2_q, vis2_q;
  logic [pvp_pkg::UREG_W-1:0] dz2_q;
  // stage 3
  logic [pvp_pkg::N_W-1:0] nx_q, ny_q;
  logic negx3_q, negy3_q, vis3_q;
  logic [pvp_pkg::UREG_W-1:0] dz3_q;
  logic [pvp_pkg::DEN_W-1:0] den3;
  pvp_pkg::pvp_cell_t d4_q;

  assign dx = $signed({vx_i[pvp_pkg::COORD_W-1], vx_i})
            - $signed({cfg_i.camera_x[pvp_pkg::COORD_W-1], cfg_i.camera_x});
  assign dy = $signed({vy_i[pvp_pkg::COORD_W-1], vy_i})
            - $signed({cfg_i.camera_y[pvp_pkg::COORD_W-1], cfg_i.camera_y});
  assign dz = $signed({vz_i[pvp_pkg::COORD_W-1], vz_i})
            - $signed({cfg_i.camera_z[pvp_pkg::COORD_W-1], cfg_i.camera_z});
  assign den3 = {dz3_q, {pvp_pkg::FRAC_BITS{1'b0}}};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      vld4_q <= 1'b0;
    end else if (en_i) begin
      vld_q  <= {vld_q[1:0], vld_i};
      vld4_q <= vld_q[2];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      // x keeps its sign; y is inverted, so its sign is that of -dy
      negx_q   <= dx[pvp_pkg::DIFF_W-1];
      magx_q   <= dx[pvp_pkg::DIFF_W-1] ? pvp_pkg::DIFF_W'(-dx) : pvp_pkg::DIFF_W'(dx);
      negy_q   <= ~dy[pvp_pkg::DIFF_W-1] && (dy != '0);
      magy_q   <= dy[pvp_pkg::DIFF_W-1] ? pvp_pkg::DIFF_W'(-dy) : pvp_pkg::DIFF_W'(dy);
      vis1_q   <= (dz > $signed({2'b00, cfg_i.near_plane}))
               && (dz < $signed({2'b00, cfg_i.far_plane}));
      dz1_q    <= dz[pvp_pkg::UREG_W-1:0];
      scale1_q <= cfg_i.proj_scale;

      px_q    <= pvp_pkg::P_W'(magx_q) * pvp_pkg::P_W'(scale1_q);
      py_q    <= pvp_pkg::P_W'(magy_q) * pvp_pkg::P_W'(scale1_q);
      negx2_q <= negx_q;
      negy2_q <= negy_q;
      vis2_q  <= vis1_q;
      dz2_q   <= dz1_q;

      nx_q    <= pvp_pkg::N_W'(px_q) * pvp_pkg::N_W'(pvp_pkg::HALF_WIDTH);
      ny_q    <= pvp_pkg::N_W'(py_q) * pvp_pkg::N_W'(pvp_pkg::HALF_HEIGHT);
      negx3_q <= negx2_q;
      negy3_q <= negy2_q;
      vis3_q  <= vis2_q;
      dz3_q   <= dz2_q;

      // quotient overflow when n >= den * 2^QW; else n >> QW < den
      d4_q.lx.rem    <= nx_q[pvp_pkg::QW +: pvp_pkg::DEN_W];
      d4_q.lx.num_lo <= nx_q[pvp_pkg::QW-1:0];
      d4_q.lx.quo    <= '0;
      d4_q.lx.ov     <= nx_q[pvp_pkg::N_W-1:pvp_pkg::QW]
                     >= (pvp_pkg::N_W-pvp_pkg::QW)'(den3);
      d4_q.lx.neg    <= negx3_q;
      d4_q.ly.rem    <= ny_q[pvp_pkg::QW +: pvp_pkg::DEN_W];
      d4_q.ly.num_lo <= ny_q[pvp_pkg::QW-1:0];
      d4_q.ly.quo    <= '0;
      d4_q.ly.ov     <= ny_q[pvp_pkg::N_W-1:pvp_pkg::QW]
                     >= (pvp_pkg::N_W-pvp_pkg::QW)'(den3);
      d4_q.ly.neg    <= negy3_q;
      d4_q.den       <= den3;
      d4_q.vis       <= vis3_q;
      d4_q.depth     <= dz3_q;
    end
  end

  assign vld_o  = vld4_q;
  assign data_o = d4_q;
endmodule
`default_nettype wire

// ===== src/pvp_div_cell.sv =====
// Divider cell: one restoring quotient bit for both screen axes.
`timescale 1ns / 1ps
`default_nettype none
module pvp_div_cell (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               en_i,
  input  wire logic               vld_i,
  input  wire pvp_pkg::pvp_cell_t data_i,
  output logic                    vld_o,
  output pvp_pkg::pvp_cell_t      data_o
);
  logic               vld_q;
  pvp_pkg::pvp_cell_t data_q;
  pvp_pkg::pvp_cell_t data_d;

  function automatic pvp_pkg::pvp_lane_t div_step(pvp_pkg::pvp_lane_t l,
                                                  logic [pvp_pkg::DEN_W-1:0] den);
    logic [pvp_pkg::DEN_W:0] t;
    logic [pvp_pkg::DEN_W:0] diff;
    logic                    ge;
    pvp_pkg::pvp_lane_t      r;
    t      = {l.rem, l.num_lo[pvp_pkg::QW-1]};
    diff   = t - {1'b0, den};
    ge     = t >= {1'b0, den};
    r      = l;
    r.rem  = ge ? diff[pvp_pkg::DEN_W-1:0] : t[pvp_pkg::DEN_W-1:0];
    r.num_lo = {l.num_lo[pvp_pkg::QW-2:0], 1'b0};
    r.quo  = {l.quo[pvp_pkg::QW-2:0], ge};
    return r;
  endfunction

  always_comb begin
    data_d    = data_i;
    data_d.lx = div_step(data_i.lx, data_i.den);
    data_d.ly = div_step(data_i.ly, data_i.den);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign vld_o  = vld_q;
  assign data_o = data_q;
endmodule
`default_nettype wire

// ===== src/perspective_vertex_project.sv =====
// Top level: perspective vertex projector with configuration registers and divider chain.
//
// Usage: vertices arrive on vtx_i (valid/ready), one transfer per vertex, and each
// vertex yields exactly one result on res_o. Camera position, clip planes and
// projection scale go through cfg_we_i/cfg_idx_i/cfg_data_i; the user must write them
// only while idle, which the block does not enforce. Throughput: one vertex per cycle
// while results are taken. A vertex passes four front stages (offset and clip test,
// two products, divider setup), sixteen cells (one per quotient bit) and output register.
// All stages advance together; when the receiver stalls a pending result, the
// whole pipeline holds and vtx_i.ready drops, while the output register still
// lets a new vertex in whenever the result slot is empty or being taken.
// Reset empties the pipeline and loads the default camera (z = 10.0), near
// plane, far plane and scale values. Clipped vertices give visible = 0 and zero
// coordinates and depth.
`timescale 1ns / 1ps
`default_nettype none
module perspective_vertex_project (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  pvp_vertex_if.sink               vtx_i,
  pvp_result_if.source             res_o,
  input  wire logic                cfg_we_i,
  input  wire logic [2:0]          cfg_idx_i,
  input  wire logic [31:0]         cfg_data_i
);
  pvp_pkg::pvp_cfg_t  cfg_q;
  logic               en;
  logic               vld_c [pvp_pkg::QW+1];
  pvp_pkg::pvp_cell_t dat_c [pvp_pkg::QW+1];
  logic               out_vld_q;
  logic               vis_q;
  logic [pvp_pkg::SCR_W-1:0]  sx_q, sy_q;
  logic [pvp_pkg::UREG_W-1:0] depth_q;
  logic [pvp_pkg::SCR_W-1:0]  sx_d, sy_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.camera_x   <= 32'd0;
      cfg_q.camera_y   <= 32'd0;
      cfg_q.camera_z   <= 32'd655360;
      cfg_q.near_plane <= 31'd6554;
      cfg_q.far_plane  <= 31'd65536000;
      cfg_q.proj_scale <= 31'd113512;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        pvp_pkg::CFG_CAMERA_X:   cfg_q.camera_x   <= cfg_data_i;
        pvp_pkg::CFG_CAMERA_Y:   cfg_q.camera_y   <= cfg_data_i;
        pvp_pkg::CFG_CAMERA_Z:   cfg_q.camera_z   <= cfg_data_i;
        pvp_pkg::CFG_NEAR_PLANE: cfg_q.near_plane <= cfg_data_i[pvp_pkg::UREG_W-1:0];
        pvp_pkg::CFG_FAR_PLANE:  cfg_q.far_plane  <= cfg_data_i[pvp_pkg::UREG_W-1:0];
        pvp_pkg::CFG_PROJ_SCALE: cfg_q.proj_scale <= cfg_data_i[pvp_pkg::UREG_W-1:0];
        default: ;
      endcase
    end
  end

  assign en          = ~out_vld_q | res_o.ready;
  assign vtx_i.ready = en;

  pvp_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (vtx_i.valid),
    .vx_i   (vtx_i.vertex_x),
    .vy_i   (vtx_i.vertex_y),
    .vz_i   (vtx_i.vertex_z),
    .cfg_i  (cfg_q),
    .vld_o  (vld_c[0]),
    .data_o (dat_c[0])
  );

  for (genvar g = 0; g < pvp_pkg::QW; g++) begin : g_cell
    pvp_div_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .vld_i  (vld_c[g]),
      .data_i (dat_c[g]),
      .vld_o  (vld_c[g+1]),
      .data_o (dat_c[g+1])
    );
  end

  function automatic logic [pvp_pkg::SCR_W-1:0] finish(pvp_pkg::pvp_lane_t l,
                                                       logic [pvp_pkg::HALF_W-1:0] half);
    logic signed [pvp_pkg::T_W-1:0] base;
    logic signed [pvp_pkg::T_W-1:0] t;
    logic [pvp_pkg::SCR_W-1:0]      r;
    // positive: half + q; negative: trunc(half - x) drops one more when the
    // difference stays positive and the division left a remainder
    if (l.neg) begin
      base = $signed(pvp_pkg::T_W'(half)) - $signed(pvp_pkg::T_W'(l.quo));
      t    = ((l.rem != '0) && (base > 0)) ? base - $signed(pvp_pkg::T_W'(1)) : base;
    end else begin
      t = $signed(pvp_pkg::T_W'(half)) + $signed(pvp_pkg::T_W'(l.quo));
    end
    if (l.ov) begin
      r = l.neg ? 16'h8000 : 16'h7FFF;
    end else if (t > 32767) begin
      r = 16'h7FFF;
    end else if (t < -32768) begin
      r = 16'h8000;
    end else begin
      r = t[pvp_pkg::SCR_W-1:0];
    end
    return r;
  endfunction

  assign sx_d = finish(dat_c[pvp_pkg::QW].lx, pvp_pkg::HALF_W'(pvp_pkg::HALF_WIDTH));
  assign sy_d = finish(dat_c[pvp_pkg::QW].ly, pvp_pkg::HALF_W'(pvp_pkg::HALF_HEIGHT));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= vld_c[pvp_pkg::QW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      vis_q   <= dat_c[pvp_pkg::QW].vis;
      sx_q    <= dat_c[pvp_pkg::QW].vis ? sx_d : '0;
      sy_q    <= dat_c[pvp_pkg::QW].vis ? sy_d : '0;
      depth_q <= dat_c[pvp_pkg::QW].vis ? dat_c[pvp_pkg::QW].depth : '0;
    end
  end

  assign res_o.valid   = out_vld_q;
  assign res_o.visible = vis_q;
  assign res_o.scr_col = sx_q;
  assign res_o.scr_row = sy_q;
  assign res_o.depth   = depth_q;

  a_clip_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && !vis_q) |-> (sx_q == '0 && sy_q == '0 && depth_q == '0))
    else $error("clipped result carries nonzero fields");
  a_vis_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && vis_q) |-> (depth_q != '0))
    else $error("visible result with zero depth");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_c[pvp_pkg::QW] && out_vld_q && !res_o.ready) |=> out_vld_q)
    else $error("pending result dropped during stall");
endmodule
`default_nettype wire
